// ===== hw/rtl/tcc_pkg.sv =====
// Shared types and constants for the text console cursor and scroll engine.
package tcc_pkg;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ATTR_W-1:0] attr_t;

    localparam op_t OP_PUT   = 2'd0;
    localparam op_t OP_CLEAR = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    localparam char_t CH_BS       = 8'h08;
    localparam char_t CH_TAB      = 8'h09;
    localparam char_t CH_LF       = 8'h0A;
    localparam char_t CH_CR       = 8'h0D;
    localparam char_t CH_PRINT_LO = 8'h20;
    localparam char_t CH_PRINT_HI = 8'h7F;

    localparam int    TAB_STEP   = 8;
    localparam cell_t BLANK_CELL = 16'h0F20;
    localparam attr_t ATTR_RESET = 8'h02;

endpackage

// ===== hw/rtl/tcc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
// Text console engine: screen store, cursor, wrap, scroll, clear and cell read.
//
//  channel | signals                                   | direction | transfer
//  --------+-------------------------------------------+-----------+--------------------
//  in      | in_valid, in_ready, operation,            | in        | valid & ready
//          | char_code, cell_index                     |           |
//  out     | out_valid, out_ready, cursor_location,    | out       | valid & ready
//          | read_data                                 |           |
//  cfg     | cfg_we, cfg_data (text attribute)         | in        | cfg_we, no wait
//
//  A put passes S_DONE; an in-range cell read passes S_READ, then S_DONE (registered RAM read).
//  Scroll and clear walk the screen store once through its single write port.
//  After reset a clearing pass blanks the store: in_ready stays low until the final blank
//  has landed; configuration writes go on.
//  The result sits in an output register, so a stalled out channel does not stop
//  the next item being accepted; only its completion waits for the slot.
module text_console_cursor_scroll_core
    import tcc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [IDX_W-1:0]  cell_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LOC_W-1:0]  cursor_location,
    output logic [CELL_W-1:0] read_data,
    input  logic              cfg_we,
    input  logic [ATTR_W-1:0] cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CT_W       = $clog2(COLUMNS + TAB_STEP);
    localparam int RT_W       = $clog2(ROWS + 1);
    localparam int LW         = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    attr_t               attr_reg, attr_next;
    logic [ADDR_W-1:0]   sw_cnt_reg, sw_cnt_next;
    logic                sw_copy_reg, sw_copy_next;
    logic                wst_valid_reg, wst_valid_next;
    logic                wst_copy_reg, wst_copy_next;
    logic [ADDR_W-1:0]   wst_addr_reg, wst_addr_next;
    cell_t               wst_data_reg, wst_data_next;
    cell_t               res_data_reg, res_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [LOC_W-1:0]    out_loc_reg, out_loc_next;
    cell_t               out_data_reg, out_data_next;

    logic [ADDR_W-1:0]   cur_addr;
    logic [LW-1:0]       cur_loc;
    logic [CT_W-1:0]     col_ext;
    logic [CT_W-1:0]     col_t;
    logic [RT_W-1:0]     row_t;
    logic                printable;
    logic [ADDR_W-1:0]   ram_raddr;
    cell_t               ram_rdata;
    cell_t               ram_wdata;

    // Linear cursor address; row < ROWS and col < COLUMNS keep it in range.
    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign cur_loc   = LW'(cur_addr);
    assign col_ext   = CT_W'(col_reg);
    assign printable = (char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI);

    // Copies take their data straight from the RAM read issued in the previous cycle.
    assign ram_wdata = wst_copy_reg ? ram_rdata : wst_data_reg;

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (wst_valid_reg),
        .waddr (wst_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = attr_reg;
        sw_cnt_next    = sw_cnt_reg;
        sw_copy_next   = sw_copy_reg;
        wst_valid_next = 1'b0;
        wst_copy_next  = 1'b0;
        wst_addr_next  = wst_addr_reg;
        wst_data_next  = wst_data_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg;
        out_loc_next   = out_loc_reg;
        out_data_next  = out_data_reg;
        col_t          = col_ext;
        row_t          = RT_W'(row_reg);
        // During a sweep read one row ahead of the write pointer.
        ram_raddr      = sw_cnt_reg + ADDR_W'(COLUMNS);

        if (cfg_we)
        begin
            attr_next = cfg_data;
        end

        // Drop the result once taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                wst_valid_next = 1'b1;
                wst_addr_next  = sw_cnt_reg;
                if (sw_copy_reg && (sw_cnt_reg < ADDR_W'(COPY_COUNT)))
                begin
                    wst_copy_next = 1'b1;
                end
                else
                begin
                    wst_data_next = BLANK_CELL;
                end
                if (sw_cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    sw_cnt_next = '0;
                    state_next  = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                else
                begin
                    sw_cnt_next = sw_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    res_data_next = '0;
                    state_next    = S_DONE;
                    case (operation)
                        OP_PUT:
                        begin
                            if (char_code == CH_BS)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_t = col_ext - 1'b1;
                                end
                            end
                            else if (char_code == CH_TAB)
                            begin
                                col_t = (col_ext + CT_W'(TAB_STEP))
                                      & ~CT_W'(TAB_STEP - 1);
                            end
                            else if (char_code == CH_CR)
                            begin
                                col_t = '0;
                            end
                            else if (char_code == CH_LF)
                            begin
                                col_t = '0;
                                row_t = RT_W'(row_reg) + 1'b1;
                            end
                            else if (printable)
                            begin
                                wst_valid_next = 1'b1;
                                wst_addr_next  = cur_addr;
                                wst_data_next  = {attr_reg, char_code};
                                col_t          = col_ext + 1'b1;
                            end
                            // Wrap at the right edge.
                            if (col_t >= CT_W'(COLUMNS))
                            begin
                                col_t = '0;
                                row_t = RT_W'(row_reg) + 1'b1;
                            end
                            col_next = COL_W'(col_t);
                            // Scroll at the bottom edge: walk the store, copy up, blank the last row.
                            if (row_t >= RT_W'(ROWS))
                            begin
                                row_next     = ROW_W'(ROWS - 1);
                                sw_copy_next = 1'b1;
                                sw_cnt_next  = '0;
                                state_next   = S_SWEEP;
                            end
                            else
                            begin
                                row_next = ROW_W'(row_t);
                            end
                        end

                        OP_CLEAR:
                        begin
                            col_next     = '0;
                            row_next     = '0;
                            sw_copy_next = 1'b0;
                            sw_cnt_next  = '0;
                            state_next   = S_SWEEP;
                        end

                        OP_READ:
                        begin
                            if (LW'(cell_index) < LW'(CELL_COUNT))
                            begin
                                ram_raddr  = ADDR_W'(cell_index);
                                state_next = S_READ;
                            end
                        end

                        default:
                        begin
                            res_data_next = '0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_data_next = ram_rdata;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output slot is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_loc_next   = cur_loc[LOC_W-1:0];
                    out_data_next  = res_data_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            sw_cnt_reg    <= '0;
            sw_copy_reg   <= 1'b0;
            wst_valid_reg <= 1'b0;
            wst_copy_reg  <= 1'b0;
            wst_addr_reg  <= '0;
            wst_data_reg  <= '0;
            res_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_loc_reg   <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            sw_cnt_reg    <= sw_cnt_next;
            sw_copy_reg   <= sw_copy_next;
            wst_valid_reg <= wst_valid_next;
            wst_copy_reg  <= wst_copy_next;
            wst_addr_reg  <= wst_addr_next;
            wst_data_reg  <= wst_data_next;
            res_data_reg  <= res_data_next;
            out_valid_reg <= out_valid_next;
            out_loc_reg   <= out_loc_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Hold off while the last blank of the clearing pass is still being written,
    // so a cell read cannot overtake it.
    assign in_ready        = (state_reg == S_IDLE) && !wst_valid_reg;
    assign out_valid       = out_valid_reg;
    assign cursor_location = out_loc_reg;
    assign read_data       = out_data_reg;

endmodule

// ===== tb/sv/text_console_cursor_scroll_core_test.sv =====
// Self-checking testbench for the text console engine: cursor moves, wrap, scroll, clear, cell read.
`timescale 1ns / 100ps

module text_console_cursor_scroll_core_test;
    import tcc_pkg::*;

    // Screen geometry, passed to the block so both sides agree.
    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // The block decodes only three operations; the fourth code must leave the console unchanged.
    localparam op_t OP_UNUSED = 2'd3;

    // Long enough for a scroll or clear to walk the whole store, with slack to spare.
    // Use it for the quiet spell at the very end.
    localparam int WALK_CYCLES = SCREEN_CELLS + 100;

    // About 1900 items; even with a few hundred scrolls and clears, the reset
    // clearing pass and heavy stalls on both sides, a correct run stays well
    // inside the watchdog limit.
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        op_t              op;
        char_t            code;
        logic [IDX_W-1:0] idx;
    } console_cmd_t;

    typedef struct packed {
        logic [LOC_W-1:0] loc;
        cell_t            data;
    } cursor_cell_t;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   operation  = '0;
    logic [CHAR_W-1:0] char_code  = '0;
    logic [IDX_W-1:0]  cell_index = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] read_data;
    logic              cfg_we     = 1'b0;
    logic [ATTR_W-1:0] cfg_data   = '0;

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    console_cmd_t cmd_q[$];           // items waiting to be offered to the block
    cursor_cell_t cursor_cell_q[$];   // predicted results, oldest first

    int n_queued      = 0;            // items handed to the driver so far
    int n_results     = 0;            // results taken from the block so far
    int n_errors      = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;            // chance per cycle that the sender holds off
    int recv_idle_pct = 0;            // chance per cycle that the receiver stalls

    // Shadow copy of the console: screen store, cursor and attribute.
    cell_t screen_shadow [0:SCREEN_CELLS-1];
    int    cur_col;
    int    cur_row;
    attr_t attr_shadow;

    text_console_cursor_scroll_core #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_location (cursor_location),
        .read_data       (read_data),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: apply one accepted item to the shadow console and queue the
    // result it must produce.
    // ------------------------------------------------------------------
    function automatic void advance_console(input op_t op, input char_t code,
                                            input logic [IDX_W-1:0] idx);
        cursor_cell_t res;
        cell_t        data;
        int           i;
        data = '0;
        if (op == OP_PUT)
        begin
            if (code == CH_BS)
            begin
                // Backspace stops at the left edge.
                if (cur_col != 0)
                    cur_col--;
            end
            else if (code == CH_TAB)
            begin
                cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
            end
            else if (code == CH_CR)
            begin
                cur_col = 0;
            end
            else if (code == CH_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI)
            begin
                screen_shadow[cur_row * SCREEN_COLS + cur_col] = {attr_shadow, code};
                cur_col++;
            end
            // Wrap at the right edge, then scroll at the bottom edge.
            if (cur_col >= SCREEN_COLS)
            begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= SCREEN_ROWS)
            begin
                for (i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
                    screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
                for (i = SCREEN_COLS * (SCREEN_ROWS - 1); i < SCREEN_CELLS; i++)
                    screen_shadow[i] = BLANK_CELL;
                cur_row = SCREEN_ROWS - 1;
            end
        end
        else if (op == OP_CLEAR)
        begin
            for (i = 0; i < SCREEN_CELLS; i++)
                screen_shadow[i] = BLANK_CELL;
            cur_col = 0;
            cur_row = 0;
        end
        else if (op == OP_READ)
        begin
            // Reads beyond the screen return zero.
            if (idx < SCREEN_CELLS)
                data = screen_shadow[idx];
        end
        res.loc  = LOC_W'(cur_row * SCREEN_COLS + cur_col);
        res.data = data;
        cursor_cell_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued items, hold each until accepted, and predict on
    // acceptance. The sender idles at random between items.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        console_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= '0;
            char_code  <= '0;
            cell_index <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_console(operation, char_code, cell_index);
            // The slot is free when nothing is offered or the offer just went in.
            if (!in_valid || in_ready)
            begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = cmd_q.pop_front();
                    in_valid   <= 1'b1;
                    operation  <= nxt.op;
                    char_code  <= nxt.code;
                    cell_index <= nxt.idx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results, compare each field with the oldest prediction,
    // and stall the out channel at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        cursor_cell_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (cursor_cell_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got cursor %0d data %h",
                             $time, cursor_location, read_data);
                end
                else
                begin
                    exp_res = cursor_cell_q.pop_front();
                    if (cursor_location !== exp_res.loc)
                    begin
                        n_errors++;
                        $display("%0t: cursor_location expected %0d, got %0d",
                                 $time, exp_res.loc, cursor_location);
                    end
                    if (read_data !== exp_res.data)
                    begin
                        n_errors++;
                        $display("%0t: read_data expected %h, got %h",
                                 $time, exp_res.data, read_data);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(input op_t op, input char_t code, input logic [IDX_W-1:0] idx);
        console_cmd_t c;
        c.op   = op;
        c.code = code;
        c.idx  = idx;
        cmd_q.push_back(c);
        n_queued++;
    endtask

    // Hold until every queued item has produced its result.
    task automatic wait_until_drained();
        while (n_results != n_queued)
            @(posedge clk);
    endtask

    // Write the attribute register; only call while the block is idle.
    task automatic write_attribute(input attr_t value);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= value;
        attr_shadow  = value;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    // Mostly character puts: printable text with line breaks, so the cursor walks down the
    // screen and scrolls often; mixed with reads, cursor controls, ignored
    // bytes, the odd clear and the undecoded operation.
    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int           pick;
        int           sel;
        c.op   = OP_PUT;
        c.code = char_t'($urandom);
        c.idx  = IDX_W'($urandom);
        pick   = $urandom_range(999);
        if (pick < 2)
        begin
            c.op = OP_CLEAR;
        end
        else if (pick < 12)
        begin
            c.op = OP_UNUSED;
        end
        else if (pick < 212)
        begin
            c.op = OP_READ;
            sel  = $urandom_range(9);
            if (sel < 4)
                c.idx = IDX_W'($urandom_range(2047));   // whole range, beyond the screen too
            else if (sel < 7)
                c.idx = IDX_W'($urandom_range(399));    // top rows, where text lands first
            else
                c.idx = IDX_W'($urandom_range(SCREEN_CELLS - 1, SCREEN_CELLS - SCREEN_COLS));
        end
        else
        begin
            sel = $urandom_range(99);
            if (sel < 55)
            begin
                c.code = char_t'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
            end
            else if (sel < 65)
            begin
                c.code = CH_LF;
            end
            else if (sel < 70)
            begin
                c.code = CH_CR;
            end
            else if (sel < 77)
            begin
                c.code = CH_BS;
            end
            else if (sel < 85)
            begin
                c.code = CH_TAB;
            end
            else if (sel < 92)
            begin
                c.code = char_t'($urandom_range(8'hFF, 8'h80));
            end
            else
            begin
                // Low control bytes that the console ignores.
                c.code = char_t'($urandom_range(CH_PRINT_LO - 1));
                while (c.code == CH_BS || c.code == CH_TAB || c.code == CH_LF ||
                       c.code == CH_CR)
                    c.code = char_t'($urandom_range(CH_PRINT_LO - 1));
            end
        end
        return c;
    endfunction

    task automatic queue_random(input int count);
        console_cmd_t c;
        int           k;
        for (k = 0; k < count; k++)
        begin
            c = random_cmd();
            queue_cmd(c.op, c.code, c.idx);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        // Initialise the shadow console to its reset state.
        for (k = 0; k < SCREEN_CELLS; k++)
            screen_shadow[k] = BLANK_CELL;
        cur_col     = 0;
        cur_row     = 0;
        attr_shadow = ATTR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset attribute; the block is still in its
        // clearing pass, so the first item waits on in_ready.
        send_idle_pct = 24;
        recv_idle_pct = 63;
        queue_cmd(OP_PUT,    CH_BS,       '0);     // backspace at column 0: no move
        queue_cmd(OP_PUT,    CH_PRINT_LO, '0);     // lowest printable
        queue_cmd(OP_PUT,    CH_PRINT_HI, 11'h7FF); // highest printable
        queue_cmd(OP_PUT,    CH_BS,       '0);
        queue_cmd(OP_PUT,    CH_TAB,      '0);
        queue_cmd(OP_PUT,    8'h41,       '0);
        queue_cmd(OP_PUT,    CH_CR,       '0);
        queue_cmd(OP_PUT,    CH_LF,       '0);
        queue_cmd(OP_PUT,    8'h00,       '0);     // ignored bytes at both ends
        queue_cmd(OP_PUT,    8'h1F,       '0);
        queue_cmd(OP_PUT,    8'h80,       '0);
        queue_cmd(OP_PUT,    8'hFF,       '0);
        queue_cmd(OP_READ,   8'hFF,       11'd0);
        queue_cmd(OP_READ,   '0,          11'd1);
        queue_cmd(OP_READ,   '0,          11'd2);
        queue_cmd(OP_READ,   '0,          11'd1999);
        queue_cmd(OP_READ,   '0,          11'd2000); // first index beyond the screen
        queue_cmd(OP_READ,   '0,          11'h7FF);
        queue_cmd(OP_UNUSED, 8'hFF,       11'h7FF);
        queue_cmd(OP_CLEAR,  8'hFF,       11'h7FF);
        queue_cmd(OP_READ,   '0,          11'd0);
        for (k = 0; k < 10; k++)
            queue_cmd(OP_PUT, CH_TAB, '0);          // tabs across the right edge
        wait_until_drained();

        // Random part, first idling pattern; pause the sender once mid-way.
        write_attribute(8'hFF);
        queue_random(300);
        wait_until_drained();
        queue_random(317);
        wait_until_drained();

        // Swap the idling pattern.
        write_attribute(8'h00);
        send_idle_pct = 63;
        recv_idle_pct = 24;
        queue_random(610);
        wait_until_drained();

        // Full speed on both sides.
        write_attribute(attr_t'($urandom_range(254, 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(610);
        wait_until_drained();

        // Leave room for a late or stray result.
        recv_idle_pct = 0;
        repeat (WALK_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
